/* rtl/core/tty_line_discipline_macros.svh */
// ----------------------------------------------------------------------------
// TTY line discipline assertion macros
// Shorthand for clocked checks on clock with reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef TTY_LINE_DISCIPLINE_MACROS_SVH
`define TTY_LINE_DISCIPLINE_MACROS_SVH

// same-cycle implication
`define TTYLD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tty line discipline check failed");

// next-cycle implication
`define TTYLD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tty line discipline check failed");

`endif

/* rtl/core/ttyld_pkg.sv */
// ----------------------------------------------------------------------------
// TTY line discipline package
// Sizes, codes, control characters and byte transforms shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttyld_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int LINE_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int LINE_AW    = $clog2(LINE_DEPTH);

   localparam logic [RING_AW:0] RING_FULL = (RING_AW+1)'(RING_DEPTH);
   localparam logic [LINE_AW:0] LINE_FULL = (LINE_AW+1)'(LINE_DEPTH);

   typedef enum logic [2:0] {
      REQ_RECEIVE = 3'd0,
      REQ_WRITE   = 3'd1,
      REQ_READ    = 3'd2,
      REQ_DRAIN   = 3'd3,
      REQ_FLUSH   = 3'd4
   } req_code_type;

   localparam logic [2:0] CSR_INPUT_MODES  = 3'd0;
   localparam logic [2:0] CSR_LOCAL_MODES  = 3'd1;
   localparam logic [2:0] CSR_OUTPUT_MODES = 3'd2;
   localparam logic [2:0] CSR_CTRL_CHARS   = 3'd3;
   localparam logic [2:0] CSR_FG_GROUP     = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic [1:0] SIG_NONE = 2'd0;
   localparam logic [1:0] SIG_INTR = 2'd1;
   localparam logic [1:0] SIG_QUIT = 2'd2;
   localparam logic [1:0] SIG_STOP = 2'd3;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_CTRL  = 8'h20;
   localparam logic [7:0] MASK_7   = 8'h7f;

   localparam logic [3:0]  INPUT_MODES_RST  = 4'd2;
   localparam logic [4:0]  LOCAL_MODES_RST  = 5'd31;
   localparam logic [1:0]  OUTPUT_MODES_RST = 2'd3;
   localparam logic [63:0] CTRL_CHARS_RST   = 64'd1306902581023;

   typedef enum int unsigned {
      CC_INTR = 0, CC_QUIT = 1, CC_SUSP = 2, CC_ERASE = 3,
      CC_KILL = 4, CC_WERASE = 5, CC_EOF = 6, CC_EOL = 7
   } cc_slot_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      cnt;
   } echo_type;

   typedef struct packed {
      logic       drop;
      logic [7:0] b;
   } rx_type;

   function automatic logic [7:0] cc_byte(input logic [63:0] cc, input cc_slot_type k);
      return cc[8*k +: 8];
   endfunction

   function automatic rx_type rx_xform(input logic [7:0] din, input logic [3:0] im);
      rx_type r;
      r.drop = 1'b0;
      r.b    = im[0] ? (din & MASK_7) : din;
      if (r.b == CH_CR) begin
         if (im[3]) begin
            r.drop = 1'b1;
         end else if (im[1]) begin
            r.b = CH_NL;
         end
      end else if (r.b == CH_NL && im[2]) begin
         r.b = CH_CR;
      end
      return r;
   endfunction

   function automatic echo_type echo_of(input logic [7:0] b, input logic [4:0] lm,
                                        input logic [1:0] om);
      echo_type e;
      e = '0;
      if (!lm[2]) begin
         e.cnt = 2'd0;
      end else if (b < CH_CTRL && b != CH_NL && b != CH_TAB && b != CH_CR && lm[3]) begin
         e.bytes[0] = CH_CARET;
         e.bytes[1] = b + CH_AT;
         e.cnt      = 2'd2;
      end else if (b == CH_NL && om[0] && om[1]) begin
         e.bytes[0] = CH_CR;
         e.bytes[1] = CH_NL;
         e.cnt      = 2'd2;
      end else begin
         e.bytes[0] = b;
         e.cnt      = 2'd1;
      end
      return e;
   endfunction

   function automatic echo_type rub_echo(input logic [4:0] lm);
      echo_type e;
      e = '0;
      if (lm[2] && lm[3]) begin
         e.bytes[0] = CH_BS;
         e.bytes[1] = CH_SP;
         e.bytes[2] = CH_BS;
         e.cnt      = 2'd3;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ttyld_ram.sv */
// ----------------------------------------------------------------------------
// TTY line discipline RAM
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyld_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tty_line_discipline.sv */
// ----------------------------------------------------------------------------
// TTY line discipline
// Canonical/raw terminal input editing with input, output and line stores.
//
//   channel   ports                      transfer
//   request   start, busy, req_*         start high while busy low
//   result    rsp_valid, rsp_*           one cycle strobe, cannot stall
//   csr       csr_write_enable, csr_*    every edge with write enable high
//
// Write and plain receive move echoed bytes into the output ring one by one;
// read and drain wait for the registered store read. Kill and word-erase drop
// line bytes one by one, each with its erase echo; a line commit copies line
// bytes one by one, paced by the single read port of the line store. Reset is
// synchronous and clears all pointers and counts; stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tty_line_discipline (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   output logic [7:0]       rsp_result_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_line_end,
   output logic             rsp_end_of_input,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_signal_kind,
   output logic [31:0]      rsp_signal_group,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   import ttyld_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RECV  = 11'b00000000010,
      S_ECHO  = 11'b00000000100,
      S_KILL  = 11'b00000001000,
      S_WREAD = 11'b00000010000,
      S_WCHK  = 11'b00000100000,
      S_CREAD = 11'b00001000000,
      S_CWR   = 11'b00010000000,
      S_RWAIT = 11'b00100000000,
      S_DWAIT = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [3:0]  imodes_ff;
   logic [4:0]  lmodes_ff;
   logic [1:0]  omodes_ff;
   logic [63:0] cc_ff;
   logic [31:0] fg_ff;

   logic [2:0]  op_ff, op_in;
   logic [7:0]  byte_ff, byte_in;

   logic [RING_AW-1:0] ihead_ff, ihead_in, itail_ff, itail_in;
   logic [RING_AW:0]   ifill_ff, ifill_in;
   logic [RING_AW-1:0] ohead_ff, ohead_in, otail_ff, otail_in;
   logic [RING_AW:0]   ofill_ff, ofill_in;
   logic [LINE_AW:0]   llen_ff, llen_in, cidx_ff, cidx_in;
   logic               eof_ff, eof_in, phase_ff, phase_in;

   echo_type   eq_ff, eq_in, echo_val;
   logic [1:0] eqi_ff, eqi_in;
   logic       echo_go;
   state_type  echo_ret;

   logic [7:0]  rbyte_ff, rbyte_in;
   logic        rbv_ff, rbv_in, rle_ff, rle_in, reoi_ff, reoi_in;
   logic [1:0]  rstat_ff, rstat_in, rsig_ff, rsig_in;
   logic [31:0] rgrp_ff, rgrp_in;

   logic               iwr_en, ird_en, owr_en, ord_en, lwr_en, lrd_en;
   logic [RING_AW-1:0] iwr_addr, ird_addr, owr_addr, ord_addr;
   logic [LINE_AW-1:0] lwr_addr, lrd_addr;
   logic [7:0]         iwr_data, ird_data, owr_data, ord_data, lwr_data, lrd_data;

   rx_type     rx;
   logic       accept;
   logic [1:0] sig;
   logic [RING_AW:0] ofree;

   ttyld_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_in_ram (
      .clock(clock), .wr_en(iwr_en), .wr_addr(iwr_addr), .wr_data(iwr_data),
      .rd_en(ird_en), .rd_addr(ird_addr), .rd_data(ird_data));

   ttyld_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_out_ram (
      .clock(clock), .wr_en(owr_en), .wr_addr(owr_addr), .wr_data(owr_data),
      .rd_en(ord_en), .rd_addr(ord_addr), .rd_data(ord_data));

   ttyld_ram #(.DEPTH(LINE_DEPTH), .WIDTH(8)) u_line_ram (
      .clock(clock), .wr_en(lwr_en), .wr_addr(lwr_addr), .wr_data(lwr_data),
      .rd_en(lrd_en), .rd_addr(lrd_addr), .rd_data(lrd_data));

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == S_DONE);

   assign rsp_result_byte  = rbyte_ff;
   assign rsp_byte_valid   = rbv_ff;
   assign rsp_line_end     = rle_ff;
   assign rsp_end_of_input = reoi_ff;
   assign rsp_status       = rstat_ff;
   assign rsp_signal_kind  = rsig_ff;
   assign rsp_signal_group = rgrp_ff;

   assign rx    = rx_xform(byte_ff, imodes_ff);
   assign ofree = RING_FULL - ofill_ff;

   always_comb begin
      sig = SIG_NONE;
      if (lmodes_ff[0]) begin
         if (rx.b == cc_byte(cc_ff, CC_INTR)) begin
            sig = SIG_INTR;
         end else if (rx.b == cc_byte(cc_ff, CC_QUIT)) begin
            sig = SIG_QUIT;
         end else if (rx.b == cc_byte(cc_ff, CC_SUSP)) begin
            sig = SIG_STOP;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      op_in    = op_ff;
      byte_in  = byte_ff;
      ihead_in = ihead_ff;
      itail_in = itail_ff;
      ifill_in = ifill_ff;
      ohead_in = ohead_ff;
      otail_in = otail_ff;
      ofill_in = ofill_ff;
      llen_in  = llen_ff;
      cidx_in  = cidx_ff;
      eof_in   = eof_ff;
      phase_in = phase_ff;
      eq_in    = eq_ff;
      eqi_in   = eqi_ff;
      rbyte_in = rbyte_ff;
      rbv_in   = rbv_ff;
      rle_in   = rle_ff;
      reoi_in  = reoi_ff;
      rstat_in = rstat_ff;
      rsig_in  = rsig_ff;
      rgrp_in  = rgrp_ff;
      echo_go  = 1'b0;
      echo_val = '0;
      echo_ret = S_DONE;
      iwr_en   = 1'b0;
      iwr_addr = ihead_ff;
      iwr_data = rx.b;
      ird_en   = 1'b0;
      ird_addr = itail_ff;
      owr_en   = 1'b0;
      owr_addr = ohead_ff;
      owr_data = eq_ff.bytes[eqi_ff];
      ord_en   = 1'b0;
      ord_addr = otail_ff;
      lwr_en   = 1'b0;
      lwr_addr = llen_ff[LINE_AW-1:0];
      lwr_data = rx.b;
      lrd_en   = 1'b0;
      lrd_addr = cidx_ff[LINE_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               byte_in  = req_data_byte;
               rbyte_in = '0;
               rbv_in   = 1'b0;
               rle_in   = 1'b0;
               reoi_in  = 1'b0;
               rstat_in = STAT_OK;
               rsig_in  = SIG_NONE;
               rgrp_in  = '0;
               state_in = S_DONE;
               case (req_type)
                  REQ_RECEIVE: begin
                     state_in = S_RECV;
                  end
                  REQ_WRITE: begin
                     echo_val = '0;
                     if (req_data_byte == CH_NL && omodes_ff[0] && omodes_ff[1]) begin
                        echo_val.bytes[0] = CH_CR;
                        echo_val.bytes[1] = CH_NL;
                        echo_val.cnt      = 2'd2;
                     end else begin
                        echo_val.bytes[0] = req_data_byte;
                        echo_val.cnt      = 2'd1;
                     end
                     if (ofree < (RING_AW+1)'(echo_val.cnt)) begin
                        rstat_in = STAT_FULL;
                     end else begin
                        echo_go = 1'b1;
                     end
                  end
                  REQ_READ: begin
                     if (ifill_ff == '0) begin
                        if (eof_ff) begin
                           eof_in  = 1'b0;
                           reoi_in = 1'b1;
                        end else begin
                           rstat_in = STAT_EMPTY;
                        end
                     end else begin
                        ird_en   = 1'b1;
                        state_in = S_RWAIT;
                     end
                  end
                  REQ_DRAIN: begin
                     if (ofill_ff == '0) begin
                        rstat_in = STAT_EMPTY;
                     end else begin
                        ord_en   = 1'b1;
                        state_in = S_DWAIT;
                     end
                  end
                  REQ_FLUSH: begin
                     ihead_in = '0;
                     itail_in = '0;
                     ifill_in = '0;
                     llen_in  = '0;
                     eof_in   = 1'b0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RECV: begin
            state_in = S_DONE;
            if (rx.drop) begin
               state_in = S_DONE;
            end else if (sig != SIG_NONE) begin
               if (fg_ff != '0) begin
                  rsig_in = sig;
                  rgrp_in = fg_ff;
               end
            end else if (!lmodes_ff[1]) begin
               if (ifill_ff != RING_FULL) begin
                  iwr_en   = 1'b1;
                  ihead_in = ihead_ff + 1'b1;
                  ifill_in = ifill_ff + 1'b1;
                  echo_go  = 1'b1;
                  echo_val = echo_of(rx.b, lmodes_ff, omodes_ff);
               end
            end else if (rx.b == cc_byte(cc_ff, CC_ERASE) || rx.b == CH_BS) begin
               if (llen_ff != '0) begin
                  llen_in  = llen_ff - 1'b1;
                  echo_go  = 1'b1;
                  echo_val = rub_echo(lmodes_ff);
               end
            end else if (rx.b == cc_byte(cc_ff, CC_KILL)) begin
               state_in = S_KILL;
            end else if (rx.b == cc_byte(cc_ff, CC_WERASE) && lmodes_ff[4]) begin
               phase_in = 1'b0;
               state_in = S_WREAD;
            end else if (rx.b == cc_byte(cc_ff, CC_EOF)) begin
               if (llen_ff != '0) begin
                  cidx_in  = '0;
                  state_in = S_CREAD;
               end else begin
                  eof_in = 1'b1;
               end
            end else if (rx.b == CH_NL || rx.b == cc_byte(cc_ff, CC_EOL)) begin
               if (llen_ff != LINE_FULL) begin
                  lwr_en   = 1'b1;
                  lwr_data = CH_NL;
                  llen_in  = llen_ff + 1'b1;
               end
               cidx_in  = '0;
               echo_go  = 1'b1;
               echo_val = echo_of(CH_NL, lmodes_ff, omodes_ff);
               echo_ret = S_CREAD;
            end else if (llen_ff < LINE_FULL - 1'b1) begin
               lwr_en   = 1'b1;
               llen_in  = llen_ff + 1'b1;
               echo_go  = 1'b1;
               echo_val = echo_of(rx.b, lmodes_ff, omodes_ff);
            end
         end
         S_ECHO: begin
            if (ofill_ff != RING_FULL) begin
               owr_en   = 1'b1;
               ohead_in = ohead_ff + 1'b1;
               ofill_in = ofill_ff + 1'b1;
            end
            if (eqi_ff == eq_ff.cnt - 1'b1) begin
               state_in = ret_ff;
            end else begin
               eqi_in = eqi_ff + 1'b1;
            end
         end
         S_KILL: begin
            if (llen_ff != '0) begin
               llen_in  = llen_ff - 1'b1;
               echo_go  = 1'b1;
               echo_val = rub_echo(lmodes_ff);
               echo_ret = S_KILL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WREAD: begin
            if (llen_ff != '0) begin
               lrd_en   = 1'b1;
               lrd_addr = LINE_AW'(llen_ff - 1'b1);
               state_in = S_WCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WCHK: begin
            phase_in = phase_ff || (lrd_data != CH_SP);
            if (!phase_ff || lrd_data != CH_SP) begin
               llen_in  = llen_ff - 1'b1;
               echo_go  = 1'b1;
               echo_val = rub_echo(lmodes_ff);
               echo_ret = S_WREAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CREAD: begin
            if (cidx_ff < llen_ff) begin
               lrd_en   = 1'b1;
               state_in = S_CWR;
            end else begin
               llen_in  = '0;
               state_in = S_DONE;
            end
         end
         S_CWR: begin
            if (ifill_ff != RING_FULL) begin
               iwr_en   = 1'b1;
               iwr_data = lrd_data;
               ihead_in = ihead_ff + 1'b1;
               ifill_in = ifill_ff + 1'b1;
            end
            cidx_in  = cidx_ff + 1'b1;
            state_in = S_CREAD;
         end
         S_RWAIT: begin
            rbyte_in = ird_data;
            rbv_in   = 1'b1;
            rle_in   = lmodes_ff[1] && (ird_data == CH_NL);
            itail_in = itail_ff + 1'b1;
            ifill_in = ifill_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DWAIT: begin
            rbyte_in = ord_data;
            rbv_in   = 1'b1;
            otail_in = otail_ff + 1'b1;
            ofill_in = ofill_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // launch echo burst, skip it when empty
      if (echo_go) begin
         eq_in    = echo_val;
         eqi_in   = 2'd0;
         ret_in   = echo_ret;
         state_in = (echo_val.cnt == 2'd0) ? echo_ret : S_ECHO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_DONE;
         ihead_ff  <= '0;
         itail_ff  <= '0;
         ifill_ff  <= '0;
         ohead_ff  <= '0;
         otail_ff  <= '0;
         ofill_ff  <= '0;
         llen_ff   <= '0;
         cidx_ff   <= '0;
         eof_ff    <= 1'b0;
         phase_ff  <= 1'b0;
         eqi_ff    <= '0;
         imodes_ff <= INPUT_MODES_RST;
         lmodes_ff <= LOCAL_MODES_RST;
         omodes_ff <= OUTPUT_MODES_RST;
         cc_ff     <= CTRL_CHARS_RST;
         fg_ff     <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         ihead_ff <= ihead_in;
         itail_ff <= itail_in;
         ifill_ff <= ifill_in;
         ohead_ff <= ohead_in;
         otail_ff <= otail_in;
         ofill_ff <= ofill_in;
         llen_ff  <= llen_in;
         cidx_ff  <= cidx_in;
         eof_ff   <= eof_in;
         phase_ff <= phase_in;
         eqi_ff   <= eqi_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_INPUT_MODES:  imodes_ff <= csr_write_data[3:0];
               CSR_LOCAL_MODES:  lmodes_ff <= csr_write_data[4:0];
               CSR_OUTPUT_MODES: omodes_ff <= csr_write_data[1:0];
               CSR_CTRL_CHARS:   cc_ff     <= csr_write_data;
               CSR_FG_GROUP:     fg_ff     <= csr_write_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      byte_ff  <= byte_in;
      eq_ff    <= eq_in;
      rbyte_ff <= rbyte_in;
      rbv_ff   <= rbv_in;
      rle_ff   <= rle_in;
      reoi_ff  <= reoi_in;
      rstat_ff <= rstat_in;
      rsig_ff  <= rsig_in;
      rgrp_ff  <= rgrp_in;
   end

`include "tty_line_discipline_macros.svh"

   `TTYLD_ASSERT_NEXT(a_rsp_one_cycle, rsp_valid, !rsp_valid)
   `TTYLD_ASSERT_NEXT(a_accept_busy, accept, busy && (op_ff == $past(req_type)))
   `TTYLD_ASSERT_NOW(a_ring_bounds, 1'b1, ifill_ff <= RING_FULL && ofill_ff <= RING_FULL)
   `TTYLD_ASSERT_NOW(a_line_bound, 1'b1, llen_ff <= LINE_FULL)

endmodule

`default_nettype wire

/* tb/sv/tty_line_discipline_test.sv */
// ----------------------------------------------------------------------------
// TTY line discipline testbench
// Drives receive, write, read, drain, flush and undefined requests through the
// command port under several register settings, predicts every result with an
// in-bench model of the rings and the line editor, and checks each result
// strobe field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tty_line_discipline_test;
   import ttyld_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef enum logic {ITEM_REQ, ITEM_CSR} item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [2:0]    rtype;
      logic [7:0]    dbyte;
      logic [2:0]    cidx;
      logic [63:0]   cdata;
      int            idle;
   } tty_item_type;

   typedef struct packed {
      logic [7:0]  rbyte;
      logic        bvalid;
      logic        lend;
      logic        eoi;
      logic [1:0]  status;
      logic [1:0]  skind;
      logic [31:0] sgroup;
   } tty_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_result_byte;
   logic        rsp_byte_valid;
   logic        rsp_line_end;
   logic        rsp_end_of_input;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_signal_kind;
   logic [31:0] rsp_signal_group;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   tty_line_discipline uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [3:0]         m_imode = INPUT_MODES_RST;
   logic [4:0]         m_lmode = LOCAL_MODES_RST;
   logic [1:0]         m_omode = OUTPUT_MODES_RST;
   logic [63:0]        m_cc    = CTRL_CHARS_RST;
   logic [31:0]        m_fg    = '0;
   logic [7:0]         in_mem  [RING_DEPTH];
   logic [7:0]         out_mem [RING_DEPTH];
   logic [7:0]         line_mem[LINE_DEPTH];
   logic [RING_AW-1:0] in_head = '0, in_tail = '0, out_head = '0, out_tail = '0;
   int                 in_fill = 0, out_fill = 0, line_len = 0;
   logic               eof_pend = 1'b0;

   tty_item_type pending[$];
   tty_rsp_type  rsp_expected[$];
   tty_item_type cur;
   int           errors = 0;
   int           checked = 0;
   int           cycles = 0;
   int           phases = 0;
   logic [63:0]  gen_cc = CTRL_CHARS_RST;

   function automatic logic [7:0] ctl(int k);
      return m_cc[8*k +: 8];
   endfunction

   function automatic void in_put(logic [7:0] b);
      if (in_fill >= RING_DEPTH) return;
      in_mem[in_head] = b;
      in_head++;
      in_fill++;
   endfunction

   function automatic void out_put(logic [7:0] b);
      if (out_fill >= RING_DEPTH) return;
      out_mem[out_head] = b;
      out_head++;
      out_fill++;
   endfunction

   function automatic void echo_out(logic [7:0] b);
      if (!m_lmode[2]) return;
      if (b < CH_SP && b != CH_NL && b != CH_TAB && b != CH_CR && m_lmode[3]) begin
         out_put(CH_CARET);
         out_put(b + CH_AT);
      end else if (b == CH_NL && m_omode[0] && m_omode[1]) begin
         out_put(CH_CR);
         out_put(CH_NL);
      end else begin
         out_put(b);
      end
   endfunction

   function automatic void rub_out();
      if (line_len == 0) return;
      line_len--;
      if (m_lmode[2] && m_lmode[3]) begin
         out_put(CH_BS);
         out_put(CH_SP);
         out_put(CH_BS);
      end
   endfunction

   function automatic void commit_line();
      for (int i = 0; i < line_len; i++) in_put(line_mem[i]);
      line_len = 0;
   endfunction

   function automatic logic [1:0] take_rx(logic [7:0] din);
      logic [7:0] b;
      b = m_imode[0] ? (din & MASK_7) : din;
      if (b == CH_CR) begin
         if (m_imode[3]) return SIG_NONE;
         if (m_imode[1]) b = CH_NL;
      end else if (b == CH_NL && m_imode[2]) begin
         b = CH_CR;
      end
      if (m_lmode[0]) begin
         if (b == ctl(CC_INTR)) return SIG_INTR;
         if (b == ctl(CC_QUIT)) return SIG_QUIT;
         if (b == ctl(CC_SUSP)) return SIG_STOP;
      end
      if (!m_lmode[1]) begin
         if (in_fill < RING_DEPTH) begin
            in_put(b);
            echo_out(b);
         end
      end else if (b == ctl(CC_ERASE) || b == CH_BS) begin
         rub_out();
      end else if (b == ctl(CC_KILL)) begin
         while (line_len > 0) rub_out();
      end else if (b == ctl(CC_WERASE) && m_lmode[4]) begin
         while (line_len > 0 && line_mem[line_len-1] == CH_SP) rub_out();
         while (line_len > 0 && line_mem[line_len-1] != CH_SP) rub_out();
      end else if (b == ctl(CC_EOF)) begin
         if (line_len > 0) commit_line();
         else eof_pend = 1'b1;
      end else if (b == CH_NL || b == ctl(CC_EOL)) begin
         if (line_len < LINE_DEPTH) begin
            line_mem[line_len] = CH_NL;
            line_len++;
         end
         echo_out(CH_NL);
         commit_line();
      end else if (line_len < LINE_DEPTH - 1) begin
         line_mem[line_len] = b;
         line_len++;
         echo_out(b);
      end
      return SIG_NONE;
   endfunction

   function automatic tty_rsp_type tty_predict(logic [2:0] rt, logic [7:0] b);
      tty_rsp_type r;
      logic [1:0]  sig;
      logic        crlf;
      r = '0;
      case (rt)
         REQ_RECEIVE: begin
            sig = take_rx(b);
            if (sig != SIG_NONE && m_fg != 0) begin
               r.skind  = sig;
               r.sgroup = m_fg;
            end
         end
         REQ_WRITE: begin
            crlf = b == CH_NL && m_omode[0] && m_omode[1];
            if (out_fill + (crlf ? 2 : 1) > RING_DEPTH) begin
               r.status = STAT_FULL;
            end else if (crlf) begin
               out_put(CH_CR);
               out_put(CH_NL);
            end else begin
               out_put(b);
            end
         end
         REQ_READ: begin
            if (in_fill == 0) begin
               if (eof_pend) begin
                  eof_pend = 1'b0;
                  r.eoi    = 1'b1;
               end else begin
                  r.status = STAT_EMPTY;
               end
            end else begin
               r.rbyte  = in_mem[in_tail];
               r.bvalid = 1'b1;
               r.lend   = m_lmode[1] && in_mem[in_tail] == CH_NL;
               in_tail++;
               in_fill--;
            end
         end
         REQ_DRAIN: begin
            if (out_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.rbyte  = out_mem[out_tail];
               r.bvalid = 1'b1;
               out_tail++;
               out_fill--;
            end
         end
         REQ_FLUSH: begin
            in_head  = '0;
            in_tail  = '0;
            in_fill  = 0;
            line_len = 0;
            eof_pend = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [63:0] d);
      case (idx)
         CSR_INPUT_MODES:  m_imode = d[3:0];
         CSR_LOCAL_MODES:  m_lmode = d[4:0];
         CSR_OUTPUT_MODES: m_omode = d[1:0];
         CSR_CTRL_CHARS:   m_cc    = d;
         CSR_FG_GROUP:     m_fg    = d[31:0];
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      logic nxt_start;
      logic nxt_we;
      tty_item_type it;
      nxt_we    = 1'b0;
      nxt_start = start;
      if (!reset) begin
         if (start && !busy) begin
            rsp_expected.push_back(tty_predict(cur.rtype, cur.dbyte));
            nxt_start = 1'b0;
         end
         if (!nxt_start && pending.size() > 0) begin
            if (pending[0].kind == ITEM_CSR) begin
               if (rsp_expected.size() == 0 && !busy) begin
                  it = pending.pop_front();
                  csr_index      <= it.cidx;
                  csr_write_data <= it.cdata;
                  nxt_we = 1'b1;
                  apply_csr(it.cidx, it.cdata);
               end
            end else if ($urandom_range(99) >= pending[0].idle) begin
               cur = pending.pop_front();
               req_type      <= cur.rtype;
               req_data_byte <= cur.dbyte;
               nxt_start = 1'b1;
            end
         end
      end
      start            <= nxt_start;
      csr_write_enable <= nxt_we;
   end

   function automatic int field_ok(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         return 1;
      end
      return 0;
   endfunction

   // monitor
   always @(posedge clock) begin
      tty_rsp_type e;
      int bad;
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            $error("result strobe with no transfer outstanding");
            errors++;
         end else begin
            e = rsp_expected.pop_front();
            bad = field_ok("result_byte", e.rbyte, rsp_result_byte)
                + field_ok("byte_valid", e.bvalid, rsp_byte_valid)
                + field_ok("line_end", e.lend, rsp_line_end)
                + field_ok("end_of_input", e.eoi, rsp_end_of_input)
                + field_ok("status", e.status, rsp_status)
                + field_ok("signal_kind", e.skind, rsp_signal_kind)
                + field_ok("signal_group", e.sgroup, rsp_signal_group);
            if (bad != 0) errors++;
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_req(logic [2:0] t, logic [7:0] b, int idle);
      tty_item_type it;
      it.kind  = ITEM_REQ;
      it.rtype = t;
      it.dbyte = b;
      it.cidx  = '0;
      it.cdata = '0;
      it.idle  = idle;
      pending.push_back(it);
   endtask

   task automatic push_cfg(logic [3:0] im, logic [4:0] lm, logic [1:0] om,
                           logic [63:0] cc, logic [31:0] fg);
      tty_item_type it;
      logic [63:0]  v[5];
      v = '{64'(im), 64'(lm), 64'(om), cc, 64'(fg)};
      it.kind  = ITEM_CSR;
      it.rtype = '0;
      it.dbyte = '0;
      it.idle  = 0;
      for (int i = 0; i < 5; i++) begin
         it.cidx  = 3'(i);
         it.cdata = v[i];
         pending.push_back(it);
      end
      gen_cc = cc;
      phases++;
   endtask

   function automatic logic [7:0] rx_pick();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 8'h61 + 8'($urandom_range(25));
      if (r < 57) return CH_SP;
      if (r < 65) return CH_NL;
      if (r < 70) return CH_CR;
      if (r < 85) return gen_cc[8*$urandom_range(7) +: 8];
      if (r < 90) return CH_BS;
      return 8'($urandom);
   endfunction

   task automatic push_random(int n, int idle);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 50)      push_req(REQ_RECEIVE, rx_pick(), idle);
         else if (r < 70) push_req(REQ_READ, 8'($urandom), idle);
         else if (r < 88) push_req(REQ_DRAIN, 8'($urandom), idle);
         else if (r < 95) push_req(REQ_WRITE, ($urandom_range(3) == 0) ? CH_NL : 8'($urandom),
                                   idle);
         else if (r < 97) push_req(REQ_FLUSH, 8'($urandom), idle);
         else             push_req(3'($urandom_range(7, 5)), 8'($urandom), idle);
      end
   endtask

   function automatic logic [63:0] rand_cc();
      logic [63:0] c;
      c = CTRL_CHARS_RST;
      for (int k = 0; k < 8; k++)
         if ($urandom_range(2) == 0) c[8*k +: 8] = 8'($urandom);
      return c;
   endfunction

   initial begin
      logic [7:0] dc[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: editing, signals, end of file, writes, empty reads
      push_cfg(INPUT_MODES_RST, LOCAL_MODES_RST, OUTPUT_MODES_RST, CTRL_CHARS_RST,
               32'h5a5a_0001);
      dc = '{8'h78, 8'h79, CH_BS, 8'h7a, CH_SP, 8'h71, gen_cc[8*CC_WERASE +: 8],
             8'h77, gen_cc[8*CC_ERASE +: 8], 8'h01, gen_cc[8*CC_KILL +: 8], 8'h6b,
             gen_cc[8*CC_EOF +: 8], gen_cc[8*CC_EOF +: 8], CH_CR, 8'hff,
             gen_cc[8*CC_INTR +: 8], gen_cc[8*CC_QUIT +: 8], gen_cc[8*CC_SUSP +: 8]};
      foreach (dc[i]) push_req(REQ_RECEIVE, dc[i], 0);
      repeat (5) push_req(REQ_READ, 8'h00, 0);
      push_req(REQ_WRITE, CH_NL, 0);
      push_req(REQ_WRITE, 8'hff, 0);
      push_req(REQ_WRITE, 8'h00, 0);
      push_req(REQ_FLUSH, 8'h00, 0);
      push_req(REQ_READ, 8'hff, 0);
      push_req(3'd7, 8'hff, 0);
      repeat (40) push_req(REQ_DRAIN, 8'h00, 0);

      // random phases over several register settings
      push_cfg(4'h0, 5'h00, 2'h0, 64'h0, 32'h0);
      push_random(120, 54);
      push_cfg(4'hf, 5'h1f, 2'h3, '1, '1);
      push_random(120, 34);
      push_cfg(4'h8, 5'h1e, 2'h1, rand_cc(), $urandom);
      push_random(150, 0);
      push_cfg(4'($urandom), 5'($urandom), 2'($urandom), rand_cc(), $urandom);
      push_random(120, 54);
      push_cfg(4'h2, 5'h1f, 2'h3, CTRL_CHARS_RST, $urandom);
      push_random(160, 34);

      // long lines: fill the line store, kill with erase echo, fill output ring
      push_cfg(4'h0, 5'h1e, 2'h3, CTRL_CHARS_RST, 32'h0);
      for (int k = 0; k < 4; k++) begin
         repeat (258) push_req(REQ_RECEIVE, 8'h61 + 8'($urandom_range(25)), 0);
         push_req(REQ_RECEIVE, (k == 3) ? CH_NL : gen_cc[8*CC_KILL +: 8], 0);
      end
      repeat (20) push_req(REQ_WRITE, CH_NL, 0);
      push_req(REQ_FLUSH, 8'h00, 0);
      push_cfg(4'($urandom), 5'($urandom), 2'($urandom), rand_cc(), $urandom);
      push_random(150, 0);

      while (pending.size() > 0 || start || rsp_expected.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Checked %0d results over %0d register settings in %0d cycles.",
               checked, phases, cycles);
      if (errors == 0 && rsp_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ttyld_pkg.sv
rtl/core/ttyld_ram.sv
rtl/core/tty_line_discipline.sv
tb/sv/tty_line_discipline_test.sv
